@@ rtl/tspid_pkg.sv @@
// Shared types and constants for the transport stream PID filter.
// Used by the front queue, the parser back end and the top level.
`default_nettype none
package tspid_pkg;

  localparam int unsigned PacketBytesDef = 188;
  localparam int unsigned QueueDepthDef  = 4;
  localparam int unsigned PidW           = 13;
  localparam int unsigned CntW           = 32;

  localparam logic [7:0]      SYNC_MARKER = 8'h47;
  localparam logic [PidW-1:0] NULL_PID    = 13'h1FFF;
  localparam logic [3:0]      VIDEO_NIB   = 4'hE;

  // One raw byte together with the tests the parser needs on it.
  typedef struct packed {
    logic [7:0] data;
    logic       is_sync;
    logic       is_zero;
    logic       is_one;
    logic       is_video;
  } byte_cls_t;

endpackage
`default_nettype wire

@@ rtl/ts_pid_filter_es_extractor_core.sv @@
// Transport stream PID filter and elementary stream extractor, top level.
// Byte input channel (valid/stall) feeds a classifying queue; the parser
// drains it into a registered result channel (valid/stall), one result per
// input byte. Every result carries es_byte/es_valid, the sticky sync_lost
// flag and the three packet counters as they stand after that byte.
// The configuration channel (valid/ready, always ready) writes target_pid;
// write it only while no transaction is in flight.
// Each accepted byte is written into the queue at the accepting edge, then
// parsed from the queue into the result register that the receiver reads.
// Throughput: one byte per cycle while the receiver does not stall; the
// parser handles each byte against its packet state.
// When the receiver stalls, the result register holds and the queue
// absorbs up to QUEUE_DEPTH further bytes before the input stalls.
// Reset clears the queue, the parser state (expecting a sync byte), the
// counters, the sync-lost flag and target_pid; a lost sync byte halts
// parsing and counting until the next reset.
`default_nettype none
module ts_pid_filter_es_extractor_core #(
  parameter int unsigned PACKET_BYTES = tspid_pkg::PacketBytesDef,
  parameter int unsigned QUEUE_DEPTH  = tspid_pkg::QueueDepthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [tspid_pkg::PidW-1:0] cfg_target_pid_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [7:0]                 data_byte_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [7:0]                 es_byte_o,
  output      logic                       es_valid_o,
  output      logic                       sync_lost_o,
  output      logic [tspid_pkg::CntW-1:0] packets_total_o,
  output      logic [tspid_pkg::CntW-1:0] packets_matching_o,
  output      logic [tspid_pkg::CntW-1:0] packets_null_o
);

  logic [tspid_pkg::PidW-1:0] target_pid_q;
  logic                       ent_valid;
  tspid_pkg::byte_cls_t       ent;
  logic                       pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_pid_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_pid_q <= cfg_target_pid_i;
    end
  end

  tspid_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .pop_i       (pop),
    .ent_valid_o (ent_valid),
    .ent_o       (ent)
  );

  tspid_back #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .target_pid_i       (target_pid_q),
    .ent_valid_i        (ent_valid),
    .ent_i              (ent),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .es_byte_o          (es_byte_o),
    .es_valid_o         (es_valid_o),
    .sync_lost_o        (sync_lost_o),
    .packets_total_o    (packets_total_o),
    .packets_matching_o (packets_matching_o),
    .packets_null_o     (packets_null_o)
  );

`ifndef SYNTHESIS
  // Once sync is lost it never comes back before reset.
  a_sync_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_lost_o |=> sync_lost_o)
    else $error("sync_lost dropped without reset");

  // With sync lost, no packet may be counted any more.
  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_lost_o |=> ($stable(packets_total_o) && $stable(packets_matching_o)
                     && $stable(packets_null_o)))
    else $error("packet counter moved after sync loss");

  // A result without an extracted byte carries a zero byte.
  a_es_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !es_valid_o) |-> (es_byte_o == 8'h00))
    else $error("es_byte nonzero without es_valid");
`endif

endmodule
`default_nettype wire

@@ rtl/tspid_front.sv @@
// Front end: accepts stream bytes, classifies them and queues them.
// Depends on tspid_pkg for the queue entry type.
`default_nettype none
module tspid_front #(
  parameter int unsigned QUEUE_DEPTH = tspid_pkg::QueueDepthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  pop_i,
  output      logic                  ent_valid_o,
  output      tspid_pkg::byte_cls_t  ent_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  tspid_pkg::byte_cls_t q_mem [QUEUE_DEPTH];
  tspid_pkg::byte_cls_t cls;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  always_comb begin
    cls.data     = data_byte_i;
    cls.is_sync  = (data_byte_i == tspid_pkg::SYNC_MARKER);
    cls.is_zero  = (data_byte_i == 8'h00);
    cls.is_one   = (data_byte_i == 8'h01);
    cls.is_video = (data_byte_i[7:4] == tspid_pkg::VIDEO_NIB);
  end

  assign in_stall_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign ent_valid_o = (cnt_q != '0);
  assign ent_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = pop_i && ent_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tspid_back.sv @@
// Back end: packet parser, PID filter, PES header stripper and counters,
// with the registered result stage. Depends on tspid_pkg.
`default_nettype none
module tspid_back #(
  parameter int unsigned PACKET_BYTES = tspid_pkg::PacketBytesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [tspid_pkg::PidW-1:0]     target_pid_i,
  input  wire logic                           ent_valid_i,
  input  wire tspid_pkg::byte_cls_t           ent_i,
  output      logic                           pop_o,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [7:0]                     es_byte_o,
  output      logic                           es_valid_o,
  output      logic                           sync_lost_o,
  output      logic [tspid_pkg::CntW-1:0]     packets_total_o,
  output      logic [tspid_pkg::CntW-1:0]     packets_matching_o,
  output      logic [tspid_pkg::CntW-1:0]     packets_null_o
);

  localparam int unsigned PosW = $clog2(PACKET_BYTES);
  localparam int unsigned CW   = tspid_pkg::CntW;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_HDR        = 4'd1;
  localparam logic [3:0] PH_DROP       = 4'd2;
  localparam logic [3:0] PH_EMIT       = 4'd3;
  localparam logic [3:0] PH_ADAPT_LEN  = 4'd4;
  localparam logic [3:0] PH_ADAPT_SKIP = 4'd5;
  localparam logic [3:0] PH_REQ_SC     = 4'd6;
  localparam logic [3:0] PH_SEARCH_SC  = 4'd7;
  localparam logic [3:0] PH_STREAM_ID  = 4'd8;
  localparam logic [3:0] PH_LEN_HI     = 4'd9;
  localparam logic [3:0] PH_LEN_LO     = 4'd10;
  localparam logic [3:0] PH_SKIP_PES   = 4'd11;
  localparam logic [3:0] PH_SEARCH_ES  = 4'd12;
  localparam logic [3:0] PH_DELAYED    = 4'd13;

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      phase_q, phase_d;
  logic            start_q, start_d;
  logic [7:0]      hold_q, hold_d;
  logic [15:0]     skip_q, skip_d;
  logic [1:0]      zr_q, zr_d;
  logic            halt_q, halt_d;
  logic [CW-1:0]   tot_q, tot_d, match_q, match_d, null_q, null_d;

  logic            out_valid_q;
  logic [7:0]      es_q, es_d;
  logic            esv_q, esv_d;

  logic [tspid_pkg::PidW-1:0] pid;
  logic [1:0]      fctl;
  logic [15:0]     skip_dec;
  logic            srch_found;
  logic [1:0]      srch_zr;
  logic [7:0]      b;

  assign b        = ent_i.data;
  assign pop_o    = ent_valid_i && (!out_valid_q || !out_stall_i);
  assign pid      = {hold_q[4:0], b};
  assign fctl     = b[5:4];
  assign skip_dec = skip_q - 16'd1;

  // Sliding 00 00 01 detector shared by both start code searches.
  always_comb begin
    srch_found = ent_i.is_one && (zr_q == 2'd2);
    if (srch_found || !ent_i.is_zero) begin
      srch_zr = 2'd0;
    end else begin
      srch_zr = (zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    start_d = start_q;
    hold_d  = hold_q;
    skip_d  = skip_q;
    zr_d    = zr_q;
    halt_d  = halt_q;
    tot_d   = tot_q;
    match_d = match_q;
    null_d  = null_q;
    es_d    = 8'h00;
    esv_d   = 1'b0;

    // Bytes held back at the end of the previous packet leave first.
    if (pos_q < PosW'(2) && zr_q != 2'd0) begin
      esv_d = 1'b1;
      if (zr_q == 2'd2) begin
        es_d = skip_q[15:8];
        zr_d = 2'd1;
      end else begin
        es_d = skip_q[7:0];
        zr_d = 2'd0;
      end
    end

    if (!halt_q) begin
      if (pos_q == PosW'(0)) begin
        if (!ent_i.is_sync) begin
          halt_d = 1'b1;
        end else begin
          tot_d = tot_q + CW'(1);
        end
      end else if (pos_q == PosW'(1)) begin
        start_d = b[6];
        hold_d  = {3'b000, b[4:0]};
      end else if (pos_q == PosW'(2)) begin
        if (pid == target_pid_i) begin
          match_d = match_q + CW'(1);
          phase_d = PH_HDR;
        end else begin
          if (pid == tspid_pkg::NULL_PID) begin
            null_d = null_q + CW'(1);
          end
          phase_d = PH_DROP;
        end
      end else if (pos_q == PosW'(3)) begin
        if (phase_q == PH_HDR) begin
          zr_d = 2'd0;
          if (fctl == 2'd1) begin
            phase_d = start_q ? PH_REQ_SC : PH_EMIT;
          end else if (fctl == 2'd3) begin
            phase_d = PH_ADAPT_LEN;
          end else begin
            phase_d = PH_DROP;
          end
        end
      end else begin
        unique case (phase_q)
          PH_EMIT: begin
            es_d  = b;
            esv_d = 1'b1;
          end
          PH_ADAPT_LEN: begin
            skip_d = {8'h00, b};
            if (ent_i.is_zero) begin
              zr_d    = 2'd0;
              phase_d = start_q ? PH_SEARCH_SC : PH_EMIT;
            end else begin
              phase_d = PH_ADAPT_SKIP;
            end
          end
          PH_ADAPT_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) begin
              zr_d    = 2'd0;
              phase_d = start_q ? PH_SEARCH_SC : PH_EMIT;
            end
          end
          PH_REQ_SC: begin
            if (zr_q == 2'd2) begin
              if (ent_i.is_one) begin
                zr_d    = 2'd0;
                phase_d = PH_STREAM_ID;
              end else begin
                phase_d = PH_DROP;
              end
            end else if (ent_i.is_zero) begin
              zr_d = zr_q + 2'd1;
            end else begin
              phase_d = PH_DROP;
            end
          end
          PH_SEARCH_SC: begin
            zr_d = srch_zr;
            if (srch_found) begin
              phase_d = PH_STREAM_ID;
            end
          end
          PH_STREAM_ID: begin
            phase_d = ent_i.is_video ? PH_LEN_HI : PH_DROP;
          end
          PH_LEN_HI: begin
            hold_d  = b;
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            skip_d  = {hold_q, b};
            zr_d    = 2'd0;
            phase_d = ({hold_q, b} == 16'd0) ? PH_SEARCH_ES : PH_SKIP_PES;
          end
          PH_SKIP_PES: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_d = PH_EMIT;
            end
          end
          PH_SEARCH_ES: begin
            zr_d = srch_zr;
            if (srch_found) begin
              // The two zeros of the start code come out first, then each
              // byte two transactions late.
              es_d    = 8'h00;
              esv_d   = 1'b1;
              skip_d  = 16'h0001;
              phase_d = PH_DELAYED;
            end
          end
          PH_DELAYED: begin
            es_d   = skip_q[15:8];
            esv_d  = 1'b1;
            skip_d = {skip_q[7:0], b};
          end
          default: begin
          end
        endcase
      end

      if (!halt_d) begin
        if (pos_q == PosW'(PACKET_BYTES - 1)) begin
          pos_d   = '0;
          zr_d    = (phase_d == PH_DELAYED) ? 2'd2 : 2'd0;
          phase_d = PH_IDLE;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_IDLE;
      start_q     <= 1'b0;
      hold_q      <= '0;
      skip_q      <= '0;
      zr_q        <= '0;
      halt_q      <= 1'b0;
      tot_q       <= '0;
      match_q     <= '0;
      null_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pos_q       <= pos_d;
        phase_q     <= phase_d;
        start_q     <= start_d;
        hold_q      <= hold_d;
        skip_q      <= skip_d;
        zr_q        <= zr_d;
        halt_q      <= halt_d;
        tot_q       <= tot_d;
        match_q     <= match_d;
        null_q      <= null_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q               <= '0;
      esv_q              <= 1'b0;
      sync_lost_o        <= 1'b0;
      packets_total_o    <= '0;
      packets_matching_o <= '0;
      packets_null_o     <= '0;
    end else if (pop_o) begin
      es_q               <= es_d;
      esv_q              <= esv_d;
      sync_lost_o        <= halt_d;
      packets_total_o    <= tot_d;
      packets_matching_o <= match_d;
      packets_null_o     <= null_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign es_byte_o   = es_q;
  assign es_valid_o  = esv_q;

endmodule
`default_nettype wire

@@ tb/sv/ts_pid_filter_es_extractor_core_tb.sv @@
// Self-checking testbench for ts_pid_filter_es_extractor_core: feeds transport stream packets
// under random flow control and checks every result against a built-in packet parser model.
// Depends on tspid_pkg and the core RTL only.
`timescale 1ns / 100ps

module ts_pid_filter_es_extractor_core_tb;

  localparam int unsigned PKT = 188;
  localparam logic [7:0]  TS_SYNC     = 8'h47;
  localparam logic [12:0] TS_NULL_PID = 13'h1FFF;
  localparam logic [3:0]  TS_VIDEO    = 4'hE;

  typedef struct packed {
    logic [7:0]                 es_byte;
    logic                       es_valid;
    logic                       sync_lost;
    logic [tspid_pkg::CntW-1:0] total;
    logic [tspid_pkg::CntW-1:0] matching;
    logic [tspid_pkg::CntW-1:0] nulls;
  } es_result_t;

  typedef enum int {
    PES_SHORT_HDR, PES_ZERO_LEN, PES_LONG_LEN, PES_BAD_START, PES_NOT_VIDEO, PES_NO_START
  } pes_shape_e;

  // Parser model plus the queue of results it predicts.
  class es_scoreboard;
    typedef enum logic [3:0] {
      PARSE_IDLE, PARSE_HDR, PARSE_DROP, PARSE_EMIT, PARSE_ADAPT_LEN, PARSE_ADAPT_SKIP,
      PARSE_REQ_START, PARSE_SEEK_START, PARSE_STREAM_ID, PARSE_LEN_HI, PARSE_LEN_LO,
      PARSE_SKIP_HDR, PARSE_SEEK_ES, PARSE_DELAYED
    } parse_phase_e;

    logic [12:0]  target;
    logic [7:0]   pos;
    parse_phase_e phase;
    logic         pusi;
    logic [1:0]   afc;
    logic [7:0]   hold;
    logic [15:0]  skip;
    logic [1:0]   zrun;
    logic         halted;
    logic [31:0]  n_total;
    logic [31:0]  n_match;
    logic [31:0]  n_null;
    es_result_t   expected_q[$];
    int           errors;
    int           result_idx;

    function new();
      target = '0;
      pos = '0;
      phase = PARSE_IDLE;
      pusi = 1'b0;
      afc = '0;
      hold = '0;
      skip = '0;
      zrun = '0;
      halted = 1'b0;
      n_total = '0;
      n_match = '0;
      n_null = '0;
      errors = 0;
      result_idx = 0;
    endfunction

    function void set_target(logic [12:0] pid);
      target = pid;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Sliding 00 00 01 search; true on the 01 byte.
    function bit start_code_hit(logic [7:0] b);
      if (b == 8'h01 && zrun >= 2'd2) begin
        zrun = 2'd0;
        return 1'b1;
      end
      if (b == 8'h00) begin
        if (zrun < 2'd2) zrun++;
      end else begin
        zrun = 2'd0;
      end
      return 1'b0;
    endfunction

    function parse_phase_e after_adaptation();
      zrun = 2'd0;
      return pusi ? PARSE_SEEK_START : PARSE_EMIT;
    endfunction

    function void note_input(logic [7:0] b);
      es_result_t  r;
      logic [12:0] pid;
      r = '0;
      // The two bytes held back from a zero-length PES come out first.
      if (pos < 8'd2 && zrun != 2'd0) begin
        if (zrun == 2'd2) begin
          r.es_byte = skip[15:8];
          zrun = 2'd1;
        end else begin
          r.es_byte = skip[7:0];
          zrun = 2'd0;
        end
        r.es_valid = 1'b1;
      end
      if (!halted) begin
        if (pos == 8'd0) begin
          if (b != TS_SYNC) halted = 1'b1;
          else n_total++;
        end else if (pos == 8'd1) begin
          pusi = b[6];
          hold = {3'b000, b[4:0]};
        end else if (pos == 8'd2) begin
          pid = {hold[4:0], b};
          if (pid == target) begin
            n_match++;
            phase = PARSE_HDR;
          end else begin
            if (pid == TS_NULL_PID) n_null++;
            phase = PARSE_DROP;
          end
        end else if (pos == 8'd3) begin
          if (phase == PARSE_HDR) begin
            afc = b[5:4];
            zrun = 2'd0;
            if (afc == 2'd1) phase = pusi ? PARSE_REQ_START : PARSE_EMIT;
            else if (afc == 2'd3) phase = PARSE_ADAPT_LEN;
            else phase = PARSE_DROP;
          end
        end else begin
          case (phase)
            PARSE_EMIT: begin
              r.es_byte = b;
              r.es_valid = 1'b1;
            end
            PARSE_ADAPT_LEN: begin
              skip = {8'h00, b};
              phase = (b == 8'h00) ? after_adaptation() : PARSE_ADAPT_SKIP;
            end
            PARSE_ADAPT_SKIP: begin
              skip = skip - 16'd1;
              if (skip == 16'd0) phase = after_adaptation();
            end
            PARSE_REQ_START: begin
              if (b != ((zrun == 2'd2) ? 8'h01 : 8'h00)) begin
                phase = PARSE_DROP;
              end else if (zrun == 2'd2) begin
                zrun = 2'd0;
                phase = PARSE_STREAM_ID;
              end else begin
                zrun++;
              end
            end
            PARSE_SEEK_START: begin
              if (start_code_hit(b)) phase = PARSE_STREAM_ID;
            end
            PARSE_STREAM_ID: phase = (b[7:4] == TS_VIDEO) ? PARSE_LEN_HI : PARSE_DROP;
            PARSE_LEN_HI: begin
              hold = b;
              phase = PARSE_LEN_LO;
            end
            PARSE_LEN_LO: begin
              skip = {hold, b};
              zrun = 2'd0;
              phase = (skip == 16'd0) ? PARSE_SEEK_ES : PARSE_SKIP_HDR;
            end
            PARSE_SKIP_HDR: begin
              skip = skip - 16'd1;
              if (skip == 16'd0) phase = PARSE_EMIT;
            end
            PARSE_SEEK_ES: begin
              // The start code itself is emitted, two bytes late.
              if (start_code_hit(b)) begin
                r.es_byte = 8'h00;
                r.es_valid = 1'b1;
                skip = 16'h0001;
                phase = PARSE_DELAYED;
              end
            end
            PARSE_DELAYED: begin
              r.es_byte = skip[15:8];
              r.es_valid = 1'b1;
              skip = {skip[7:0], b};
            end
            default: ;
          endcase
        end
        if (!halted) begin
          pos = pos + 8'd1;
          if (pos >= PKT) begin
            pos = 8'd0;
            zrun = (phase == PARSE_DELAYED) ? 2'd2 : 2'd0;
            phase = PARSE_IDLE;
          end
        end
      end
      r.sync_lost = halted;
      r.total = n_total;
      r.matching = n_match;
      r.nulls = n_null;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH result %0d: %s", result_idx, msg);
    endtask

    task check_result(es_result_t got);
      es_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        exp = expected_q.pop_front();
        if (got.es_valid !== exp.es_valid)
          report_mismatch($sformatf("es_valid %b, expected %b", got.es_valid, exp.es_valid));
        if (got.es_byte !== exp.es_byte)
          report_mismatch($sformatf("es_byte %h, expected %h", got.es_byte, exp.es_byte));
        if (got.sync_lost !== exp.sync_lost)
          report_mismatch($sformatf("sync_lost %b, expected %b", got.sync_lost, exp.sync_lost));
        if (got.total !== exp.total)
          report_mismatch($sformatf("packets_total %0d, expected %0d", got.total, exp.total));
        if (got.matching !== exp.matching)
          report_mismatch($sformatf("packets_matching %0d, expected %0d",
                                    got.matching, exp.matching));
        if (got.nulls !== exp.nulls)
          report_mismatch($sformatf("packets_null %0d, expected %0d", got.nulls, exp.nulls));
      end
      result_idx++;
    endtask
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [tspid_pkg::PidW-1:0] cfg_pid = '0;
  logic                       in_valid = 1'b0;
  logic [7:0]                 in_data = '0;
  logic                       out_stall = 1'b0;

  logic                       cfg_ready_o;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [7:0]                 es_byte_o;
  logic                       es_valid_o;
  logic                       sync_lost_o;
  logic [tspid_pkg::CntW-1:0] packets_total_o;
  logic [tspid_pkg::CntW-1:0] packets_matching_o;
  logic [tspid_pkg::CntW-1:0] packets_null_o;

  es_scoreboard sb;
  logic [12:0]  cur_target = '0;
  bit           gapless = 1'b0;
  bit           long_hold = 1'b0;
  int           burst_left = 1;

  ts_pid_filter_es_extractor_core #(
    .PACKET_BYTES(PKT)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_target_pid_i   (cfg_pid),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (in_data),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .es_byte_o          (es_byte_o),
    .es_valid_o         (es_valid_o),
    .sync_lost_o        (sync_lost_o),
    .packets_total_o    (packets_total_o),
    .packets_matching_o (packets_matching_o),
    .packets_null_o     (packets_null_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Monitor: every handshake is sampled on the rising edge, before the edge's updates land.
  always @(posedge clk_i) begin
    es_result_t got;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o === 1'b1) sb.set_target(cfg_pid);
      if (in_valid && in_stall_o === 1'b0) sb.note_input(in_data);
      if (out_valid_o === 1'b1 && !out_stall) begin
        got.es_byte = es_byte_o;
        got.es_valid = es_valid_o;
        got.sync_lost = sync_lost_o;
        got.total = packets_total_o;
        got.matching = packets_matching_o;
        got.nulls = packets_null_o;
        sb.check_result(got);
      end
    end
  end

  // Receiver flow control: random segments of stall patterns, plus one long hold on request.
  initial begin
    int mode;
    int cyc;
    int seg;
    cyc = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(20, 200);
      while (seg > 0 && !long_hold) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % 7) < 3);
        endcase
        cyc++;
        seg--;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] fill_byte();
    int sel;
    sel = $urandom_range(0, 31);
    // Bias toward start code bytes and the sync value so the searches get exercised.
    if (sel < 4) return 8'h00;
    if (sel < 6) return 8'h01;
    if (sel == 6) return TS_SYNC;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (!gapless) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  task automatic send_packet(input logic [12:0] pid, input bit pusi, input logic [1:0] afc,
                             input pes_shape_e shape, input int alen);
    logic [7:0]  pkt[$];
    logic [31:0] rnd;
    logic [7:0]  sid;
    int          hdr_len;
    rnd = $urandom();
    pkt.push_back(TS_SYNC);
    pkt.push_back({rnd[7], pusi, rnd[5], pid[12:8]});
    pkt.push_back(pid[7:0]);
    pkt.push_back({rnd[15:14], afc, rnd[11:8]});
    if (afc == 2'd3) begin
      pkt.push_back(8'(alen));
      repeat (alen) pkt.push_back(fill_byte());
    end
    if (pusi && afc[0]) begin
      if (afc == 2'd3) repeat ($urandom_range(0, 4)) pkt.push_back(fill_byte());
      if (shape == PES_BAD_START) begin
        if (afc == 2'd1) begin
          case ($urandom_range(0, 3))
            0: pkt = {pkt, 8'h00, 8'h00, 8'h02};
            1: pkt = {pkt, 8'h00, 8'h01};
            2: pkt = {pkt, 8'h01};
            default: pkt = {pkt, 8'h00, 8'h00, 8'h00, 8'h01};
          endcase
        end
      end else if (shape != PES_NO_START) begin
        pkt = {pkt, 8'h00, 8'h00, 8'h01};
        sid = 8'($urandom_range(0, 255));
        if (shape == PES_NOT_VIDEO) begin
          if (sid[7:4] == TS_VIDEO) sid[7:4] = 4'hC;
        end else begin
          sid[7:4] = TS_VIDEO;
        end
        pkt.push_back(sid);
        case (shape)
          PES_SHORT_HDR: hdr_len = $urandom_range(1, 30);
          PES_ZERO_LEN:  hdr_len = 0;
          PES_LONG_LEN:  hdr_len = $urandom_range(180, 65535);
          default:       hdr_len = $urandom_range(0, 40);
        endcase
        pkt.push_back(8'(hdr_len >> 8));
        pkt.push_back(8'(hdr_len));
        if (shape == PES_SHORT_HDR) repeat (hdr_len) pkt.push_back(fill_byte());
        if (shape == PES_ZERO_LEN) begin
          repeat ($urandom_range(0, 6)) pkt.push_back(fill_byte());
          pkt = {pkt, 8'h00, 8'h00, 8'h01};
        end
      end
    end
    while (pkt.size() > PKT) pkt.pop_back();
    while (pkt.size() < PKT) pkt.push_back(fill_byte());
    foreach (pkt[i]) push_byte(pkt[i]);
  endtask

  // Stops offering bytes and waits until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [12:0] pid);
    cfg_valid <= 1'b1;
    cfg_pid <= pid;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    cur_target = pid;
  endtask

  initial begin
    logic [7:0] bad_sync;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero-length PES at the reset target leaves two bytes held back for the next packet.
    send_packet(13'd0, 1'b1, 2'd3, PES_ZERO_LEN, 5);
    wait_drained();

    // Null PID as the target counts as matching only. The bytes go back to back while
    // the receiver holds off long enough to fill the core.
    write_target(TS_NULL_PID);
    gapless = 1'b1;
    long_hold = 1'b1;
    send_packet(TS_NULL_PID, 1'b1, 2'd1, PES_SHORT_HDR, 0);
    gapless = 1'b0;
    wait_drained();

    write_target(13'($urandom_range(1, 8190)));
    // Held-back bytes must still flush into a packet whose sync byte is wrong.
    send_packet(cur_target, 1'b1, 2'd1, PES_ZERO_LEN, 0);
    bad_sync = 8'($urandom_range(0, 255));
    if (bad_sync == TS_SYNC) bad_sync = 8'h48;
    push_byte(bad_sync);
    repeat (29) push_byte(fill_byte());
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("ts_pid_filter_es_extractor_core_tb passed");
    end else begin
      $display("ts_pid_filter_es_extractor_core_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ts_pid_filter_es_extractor_core_tb failed");
    $finish;
  end

endmodule
